// File: rtl/lpsr_pkg.sv
// ============================================================================
// lpsr_pkg
// Shared types and constants of the length-preserving string replace block:
// stream items, front-to-back commands, configuration view, register indexes.
// ============================================================================
package lpsr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int UNPL_W      = 16;
    localparam int MAX_RESULTS = 48;

    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [UNPL_W-1:0] UNPL_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW        = 3'd0,
        REG_PATTERN_HIGH       = 3'd1,
        REG_PATTERN_LENGTH     = 3'd2,
        REG_REPLACEMENT_LOW    = 3'd3,
        REG_REPLACEMENT_HIGH   = 3'd4,
        REG_REPLACEMENT_LENGTH = 3'd5,
        REG_BINARY_MODE        = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_result;
        logic [UNPL_W-1:0] unplaced_padding;
    } t_out_item;

    typedef enum logic {
        CMD_PASS = 1'b0,
        CMD_REPL = 1'b1
    } t_cmd_kind;

    // One decision of the matcher; step_end marks the final command of an input.
    typedef struct packed {
        t_cmd_kind         kind;
        logic [BYTE_W-1:0] data_byte;
        logic              step_end;
        logic              step_last;
    } t_cmd;

    // Configuration as the datapath sees it; lengths already clamped.
    typedef struct packed {
        logic [2*CFG_W-1:0] pattern;
        logic [2*CFG_W-1:0] replacement;
        logic [LEN_W-1:0]   plen;
        logic [LEN_W-1:0]   rlen;
        logic               binary_mode;
    } t_cfg;

endpackage

// File: rtl/lpsr_fifo.sv
// ============================================================================
// lpsr_fifo
// Small synchronous FIFO on flip-flops; head entry shown while not empty.
// ============================================================================
module lpsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/lpsr_front.sv
// ============================================================================
// lpsr_front
// Match window and classifier: takes stream bytes, compares the held window
// against the pattern prefix and issues pass/replace commands to the back end.
// ============================================================================
module lpsr_front #(
    parameter int MAX_PATTERN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpsr_pkg::t_cfg     i_cfg,
    input  logic               i_push,
    input  lpsr_pkg::t_in_item i_item,
    output logic               o_full,
    output logic               o_cmd_push,
    output lpsr_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_full
);
    import lpsr_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int WIN_W  = MAX_PATTERN * BYTE_W;

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_SCAN  = 3'b010,
        F_FLUSH = 3'b100
    } t_fstate;

    t_fstate              r_state, n_state;
    logic [WIN_W-1:0]     r_win, n_win;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic                 r_last, n_last;
    logic                 r_hold_vld, n_hold_vld;
    t_cmd                 r_hold, n_hold;

    logic [FILL_W-1:0]    plen, span, drop;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic                 prefix_ok, scan_done, step_close, act;
    t_cmd                 new_cmd;

    assign plen   = i_cfg.plen[FILL_W-1:0];
    assign span   = (r_fill < plen) ? r_fill : plen;
    assign o_full = (r_state != F_IDLE);

    // Bytes beyond the compared span count as matching.
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            byte_ok[i] = (FILL_W'(i) >= span) ||
                         (r_win[i*BYTE_W +: BYTE_W] == i_cfg.pattern[i*BYTE_W +: BYTE_W]);
        end
    end

    assign prefix_ok = &byte_ok;
    assign scan_done = (r_fill == '0) || (prefix_ok && (r_fill < plen));

    always_comb begin
        n_state    = r_state;
        n_win      = r_win;
        n_fill     = r_fill;
        n_last     = r_last;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        o_cmd_push = 1'b0;
        o_cmd      = r_hold;
        step_close = 1'b0;
        act        = 1'b0;
        drop       = FILL_W'(1);
        new_cmd    = '{kind: CMD_PASS, data_byte: r_win[BYTE_W-1:0],
                       step_end: 1'b0, step_last: 1'b0};

        case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    for (int i = 0; i < MAX_PATTERN; i++) begin
                        if (FILL_W'(i) == r_fill) begin
                            n_win[i*BYTE_W +: BYTE_W] = i_item.data_byte;
                        end
                    end
                    if (r_fill != FILL_W'(MAX_PATTERN)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_last  = i_item.end_of_stream;
                    n_state = F_SCAN;
                end
            end
            F_SCAN: begin
                if (scan_done) begin
                    if (r_last && (r_fill != '0)) begin
                        n_state = F_FLUSH;
                    end else begin
                        step_close = 1'b1;
                    end
                end else begin
                    act = 1'b1;
                    if (prefix_ok) begin
                        new_cmd.kind = CMD_REPL;
                        drop         = plen;
                    end
                end
            end
            F_FLUSH: begin
                if (r_fill == '0) begin
                    step_close = 1'b1;
                end else begin
                    act = 1'b1;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase

        // The newest command is held back one decision so it can carry the end mark.
        if (step_close) begin
            if (r_hold_vld) begin
                if (!i_cmd_full) begin
                    o_cmd_push      = 1'b1;
                    o_cmd.step_end  = 1'b1;
                    o_cmd.step_last = r_last;
                    n_hold_vld      = 1'b0;
                    n_state         = F_IDLE;
                end
            end else begin
                n_state = F_IDLE;
            end
        end

        if (act && (!r_hold_vld || !i_cmd_full)) begin
            o_cmd_push = r_hold_vld;
            n_hold     = new_cmd;
            n_hold_vld = 1'b1;
            n_win      = r_win >> (BYTE_W * drop);
            n_fill     = r_fill - drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_fill     <= '0;
            r_last     <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_last     <= n_last;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_hold <= n_hold;
    end

endmodule

// File: rtl/lpsr_back.sv
// ============================================================================
// lpsr_back
// Output sequencer: expands pass/replace commands into result bytes, places
// deferred zero padding, and tags the final result of each stream.
// ============================================================================
module lpsr_back #(
    parameter int MAX_PATTERN = 16,
    parameter int PAD_LIMIT   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpsr_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_empty,
    input  lpsr_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_push,
    output lpsr_pkg::t_out_item o_res,
    input  logic                i_res_full
);
    import lpsr_pkg::*;

    localparam int ZERO_BURST = MAX_RESULTS - MAX_PATTERN;
    localparam int ZCNT_W     = $clog2(ZERO_BURST + 1);
    localparam int PEND_W     = $clog2(PAD_LIMIT + 1);
    localparam int SUM_W      = $clog2(PAD_LIMIT + MAX_PATTERN + 1);
    localparam int IDX_W      = $clog2(MAX_PATTERN + 1);

    typedef enum logic [1:0] {
        B_RUN   = 2'b01,
        B_CLOSE = 2'b10
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [PEND_W-1:0]  r_pend, n_pend;
    logic [UNPL_W-1:0]  r_lost, n_lost;
    logic               r_burst_done, n_burst_done;
    logic [ZCNT_W-1:0]  r_zcnt, n_zcnt;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_lead, n_lead;
    logic               r_hold_vld, n_hold_vld;
    logic [BYTE_W-1:0]  r_hold_byte, n_hold_byte;
    logic               r_close_last, n_close_last;

    logic [IDX_W-1:0]   plen, rlen, shortfall, rep_pos;
    logic [BYTE_W-1:0]  rep_sel, bin_char, bin_out, gen_byte;
    logic [SUM_W-1:0]   pend_sum, excess;
    logic [UNPL_W:0]    lost_sum, unpl_sum;
    logic               can_gen, gen, finish, close_done;

    assign plen      = i_cfg.plen[IDX_W-1:0];
    assign rlen      = i_cfg.rlen[IDX_W-1:0];
    assign shortfall = plen - rlen;
    assign rep_pos   = i_cfg.binary_mode ? (r_idx - shortfall) : r_idx;

    always_comb begin
        rep_sel = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (rep_pos == IDX_W'(k)) begin
                rep_sel = i_cfg.replacement[k*BYTE_W +: BYTE_W];
            end
        end
    end

    // Binary mode: right-align, then turn every leading space into a slash.
    assign bin_char = (r_idx < shortfall) ? CHAR_SPACE : rep_sel;
    assign bin_out  = (r_lead && (bin_char == CHAR_SPACE)) ? CHAR_SLASH : bin_char;

    assign pend_sum = SUM_W'(r_pend) + SUM_W'(shortfall);
    assign excess   = pend_sum - SUM_W'(PAD_LIMIT);
    assign lost_sum = {1'b0, r_lost} + (UNPL_W+1)'(excess);
    assign unpl_sum = {1'b0, r_lost} + (UNPL_W+1)'(r_pend);

    // A new byte may enter the hold stage once the previous one can leave.
    assign can_gen = !r_hold_vld || !i_res_full;

    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_lost       = r_lost;
        n_burst_done = r_burst_done;
        n_zcnt       = r_zcnt;
        n_idx        = r_idx;
        n_lead       = r_lead;
        n_hold_vld   = r_hold_vld;
        n_hold_byte  = r_hold_byte;
        n_close_last = r_close_last;
        gen          = 1'b0;
        gen_byte     = '0;
        finish       = 1'b0;
        close_done   = 1'b0;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '{out_byte: r_hold_byte, byte_valid: 1'b1,
                         last_result: 1'b0, unplaced_padding: '0};

        case (r_state)
            B_RUN: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.kind)
                        CMD_PASS: begin
                            if (can_gen) begin
                                gen = 1'b1;
                                if ((i_cmd.data_byte == '0) && (r_pend != '0) &&
                                    !r_burst_done) begin
                                    // Place one pending zero ahead of the zero byte.
                                    n_pend = r_pend - 1'b1;
                                    n_zcnt = r_zcnt + 1'b1;
                                    if ((r_pend == PEND_W'(1)) ||
                                        (r_zcnt == ZCNT_W'(ZERO_BURST - 1))) begin
                                        n_burst_done = 1'b1;
                                    end
                                end else begin
                                    gen_byte = i_cmd.data_byte;
                                    finish   = 1'b1;
                                end
                            end
                        end
                        CMD_REPL: begin
                            if (i_cfg.binary_mode) begin
                                if (can_gen) begin
                                    gen      = 1'b1;
                                    gen_byte = bin_out;
                                    n_lead   = r_lead && (bin_char == CHAR_SPACE);
                                    n_idx    = r_idx + 1'b1;
                                    if (r_idx == plen - 1'b1) begin
                                        finish = 1'b1;
                                    end
                                end
                            end else if (r_idx != rlen) begin
                                if (can_gen) begin
                                    gen      = 1'b1;
                                    gen_byte = rep_sel;
                                    n_idx    = r_idx + 1'b1;
                                end
                            end else begin
                                // Defer the shortfall; saturate and count the excess.
                                finish = 1'b1;
                                if (pend_sum > SUM_W'(PAD_LIMIT)) begin
                                    n_pend = PEND_W'(PAD_LIMIT);
                                    n_lost = lost_sum[UNPL_W] ? UNPL_MAX
                                                              : lost_sum[UNPL_W-1:0];
                                end else begin
                                    n_pend = pend_sum[PEND_W-1:0];
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_CLOSE: begin
                if (r_hold_vld || r_close_last) begin
                    if (!i_res_full) begin
                        o_res_push        = 1'b1;
                        o_res.out_byte    = r_hold_vld ? r_hold_byte : '0;
                        o_res.byte_valid  = r_hold_vld;
                        o_res.last_result = r_close_last;
                        if (r_close_last) begin
                            o_res.unplaced_padding = unpl_sum[UNPL_W] ? UNPL_MAX
                                                                      : unpl_sum[UNPL_W-1:0];
                        end
                        n_hold_vld = 1'b0;
                        close_done = 1'b1;
                    end
                end else begin
                    close_done = 1'b1;
                end
            end
            default: begin
                n_state = B_RUN;
            end
        endcase

        if (gen) begin
            o_res_push  = r_hold_vld;
            n_hold_byte = gen_byte;
            n_hold_vld  = 1'b1;
        end

        if (finish) begin
            o_cmd_pop = 1'b1;
            n_idx     = '0;
            n_lead    = 1'b1;
            if (i_cmd.step_end) begin
                n_state      = B_CLOSE;
                n_close_last = i_cmd.step_last;
            end
        end

        if (close_done) begin
            n_state      = B_RUN;
            n_burst_done = 1'b0;
            n_zcnt       = '0;
            if (r_close_last) begin
                n_pend = '0;
                n_lost = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_RUN;
            r_pend       <= '0;
            r_lost       <= '0;
            r_burst_done <= 1'b0;
            r_zcnt       <= '0;
            r_idx        <= '0;
            r_lead       <= 1'b1;
            r_hold_vld   <= 1'b0;
            r_close_last <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_lost       <= n_lost;
            r_burst_done <= n_burst_done;
            r_zcnt       <= n_zcnt;
            r_idx        <= n_idx;
            r_lead       <= n_lead;
            r_hold_vld   <= n_hold_vld;
            r_close_last <= n_close_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_byte <= n_hold_byte;
    end

endmodule

// File: rtl/length_preserving_string_replace.sv
// ============================================================================
// length_preserving_string_replace
// Streaming fixed-string find and replace that keeps the stream length, with
// slash padding (binary mode) or deferred zero padding (text mode).
// ============================================================================
//
//  channel   handshake                       payload
//  --------  ------------------------------  -----------------------------
//  input     push / full (take: push & !full) i_in_item   (t_in_item)
//  result    empty / pop (take: pop & !empty) o_out_item  (t_out_item)
//  config    i_cfg_wen, i_cfg_idx             i_cfg_wdata (64 bits)
//
//  Front: takes one byte at a time (full while busy), makes the pass or replace
//  decisions one by one, then closes an input that issued any.
//  Back: emits result bytes through a hold register, defers the shortfall of
//  each text-mode replacement, and closes each input that issued a command.
//  Reset is synchronous, active low, and clears all control state; window
//  contents are not reset. The command queue lets either side stall alone.
//
module length_preserving_string_replace #(
    parameter int MAX_PATTERN = 16,
    parameter int PAD_LIMIT   = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    input  lpsr_pkg::t_in_item                     i_in_item,
    output logic                                   full,
    output logic                                   empty,
    input  logic                                   pop,
    output lpsr_pkg::t_out_item                    o_out_item,
    input  logic                                   i_cfg_wen,
    input  logic [lpsr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lpsr_pkg::CFG_W-1:0]             i_cfg_wdata
);
    import lpsr_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_out_item);
    localparam logic [LEN_W-1:0] MAX_PLEN = LEN_W'(MAX_PATTERN);

    logic [CFG_W-1:0] r_pattern_low, r_pattern_high;
    logic [CFG_W-1:0] r_replacement_low, r_replacement_high;
    logic [LEN_W-1:0] r_pattern_length, r_replacement_length;
    logic             r_binary_mode;

    logic [LEN_W-1:0] eff_plen, eff_rlen;
    t_cfg             cfg;

    logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_cmd             front_cmd, back_cmd;
    logic [CMD_W-1:0] cmd_head;
    logic             res_push, res_full;
    t_out_item        back_res;
    logic [RES_W-1:0] res_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low        <= '0;
            r_pattern_high       <= '0;
            r_pattern_length     <= LEN_W'(1);
            r_replacement_low    <= '0;
            r_replacement_high   <= '0;
            r_replacement_length <= '0;
            r_binary_mode        <= 1'b0;
        end else if (i_cfg_wen) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PATTERN_LOW:        r_pattern_low        <= i_cfg_wdata;
                REG_PATTERN_HIGH:       r_pattern_high       <= i_cfg_wdata;
                REG_PATTERN_LENGTH:     r_pattern_length     <= i_cfg_wdata[LEN_W-1:0];
                REG_REPLACEMENT_LOW:    r_replacement_low    <= i_cfg_wdata;
                REG_REPLACEMENT_HIGH:   r_replacement_high   <= i_cfg_wdata;
                REG_REPLACEMENT_LENGTH: r_replacement_length <= i_cfg_wdata[LEN_W-1:0];
                REG_BINARY_MODE:        r_binary_mode        <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp lengths: zero acts as one, the replacement never exceeds the pattern.
    assign eff_plen = (r_pattern_length == '0) ? LEN_W'(1) :
                      (r_pattern_length > MAX_PLEN) ? MAX_PLEN : r_pattern_length;
    assign eff_rlen = (r_replacement_length > eff_plen) ? eff_plen : r_replacement_length;

    assign cfg = '{pattern:     {r_pattern_high, r_pattern_low},
                   replacement: {r_replacement_high, r_replacement_low},
                   plen:        eff_plen,
                   rlen:        eff_rlen,
                   binary_mode: r_binary_mode};

    lpsr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_item     (i_in_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (front_cmd),
        .i_cmd_full (cmd_full)
    );

    lpsr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (4)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    assign back_cmd = t_cmd'(cmd_head);

    lpsr_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .PAD_LIMIT   (PAD_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .i_res_full  (res_full)
    );

    lpsr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_out_item = t_out_item'(res_head);

endmodule
